@@ sv/asd_pkg.sv @@
// ----------------------------------------------------------------------------
// asd_pkg: shared types and constants of the step detector
// Register map, reset values, controller states and the command and status
// groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package asd_pkg;

  // Byte address width of the configuration port.
  localparam int unsigned AddrW = 5;

  // Register indexes (byte address is four times the index).
  typedef enum logic [2:0] {
    REG_GRAVITY_TAU  = 3'd0,
    REG_MOTION_TAU   = 3'd1,
    REG_THR_FRACTION = 3'd2,
    REG_THR_FLOOR    = 3'd3,
    REG_MIN_GAP      = 3'd4,
    REG_MAX_GAP      = 3'd5,
    REG_STEPS_NEEDED = 3'd6
  } reg_idx_t;

  // Register reset values.
  localparam logic [15:0] GRAVITY_TAU_RST  = 16'd1000;
  localparam logic [15:0] MOTION_TAU_RST   = 16'd60;
  localparam logic [7:0]  THR_FRACTION_RST = 8'd128;
  localparam logic [15:0] THR_FLOOR_RST    = 16'd820;
  localparam logic [15:0] MIN_GAP_RST      = 16'd250;
  localparam logic [15:0] MAX_GAP_RST      = 16'd2000;
  localparam logic [3:0]  STEPS_NEEDED_RST = 4'd4;

  // Datapath constants.
  localparam logic [31:0] LAST_PEAK_RST = 32'hFFF0_BDC0;
  localparam logic [16:0] ONE_Q16       = 17'h1_0000;
  localparam logic [16:0] PEAK_WEIGHT   = 17'd13107;
  localparam int unsigned DivSteps      = 16;

  // Current register contents.
  typedef struct packed {
    logic [15:0] gravity_tau;
    logic [15:0] motion_tau;
    logic [7:0]  thr_fraction;
    logic [15:0] thr_floor;
    logic [15:0] min_gap;
    logic [15:0] max_gap;
    logic [3:0]  steps_needed;
  } cfg_t;

  // Operand selection of the shared multiplier.
  typedef enum logic [1:0] {
    MUL_GRAVITY = 2'd0,
    MUL_MOTION  = 2'd1,
    MUL_THRESH  = 2'd2,
    MUL_PEAK    = 2'd3
  } mul_sel_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE, S_SEED, S_GSTART, S_GDIV, S_GMUL, S_GUPD, S_MSTART, S_MDIV,
    S_MMUL, S_MUPD, S_THMUL, S_DECIDE, S_PAMUL, S_PAUPD, S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     seed;
    logic     div_start;
    logic     div_motion;
    logic     calc_dyn;
    logic     mul_go;
    mul_sel_t mul_sel;
    logic     upd_g;
    logic     upd_m;
    logic     decide;
    logic     upd_pa;
    logic     load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic seeded;
    logic div_busy;
    logic pa_blend;
    logic out_busy;
  } status_t;

endpackage

@@ sv/asd_regs.sv @@
// ----------------------------------------------------------------------------
// asd_regs: configuration register file
// APB-style write and read access to the seven tuning registers.
// ----------------------------------------------------------------------------
module asd_regs
  import asd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg
);

  cfg_t     cfg_r;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
  assign cfg    = cfg_r;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gravity_tau  <= GRAVITY_TAU_RST;
      cfg_r.motion_tau   <= MOTION_TAU_RST;
      cfg_r.thr_fraction <= THR_FRACTION_RST;
      cfg_r.thr_floor    <= THR_FLOOR_RST;
      cfg_r.min_gap      <= MIN_GAP_RST;
      cfg_r.max_gap      <= MAX_GAP_RST;
      cfg_r.steps_needed <= STEPS_NEEDED_RST;
    end else if (wr_en) begin
      case (idx)
        REG_GRAVITY_TAU:  cfg_r.gravity_tau  <= pwdata[15:0];
        REG_MOTION_TAU:   cfg_r.motion_tau   <= pwdata[15:0];
        REG_THR_FRACTION: cfg_r.thr_fraction <= pwdata[7:0];
        REG_THR_FLOOR:    cfg_r.thr_floor    <= pwdata[15:0];
        REG_MIN_GAP:      cfg_r.min_gap      <= pwdata[15:0];
        REG_MAX_GAP:      cfg_r.max_gap      <= pwdata[15:0];
        REG_STEPS_NEEDED: cfg_r.steps_needed <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Read mux; unused addresses read as zero.
  always_comb begin
    case (idx)
      REG_GRAVITY_TAU:  prdata = {16'd0, cfg_r.gravity_tau};
      REG_MOTION_TAU:   prdata = {16'd0, cfg_r.motion_tau};
      REG_THR_FRACTION: prdata = {24'd0, cfg_r.thr_fraction};
      REG_THR_FLOOR:    prdata = {16'd0, cfg_r.thr_floor};
      REG_MIN_GAP:      prdata = {16'd0, cfg_r.min_gap};
      REG_MAX_GAP:      prdata = {16'd0, cfg_r.max_gap};
      REG_STEPS_NEEDED: prdata = {28'd0, cfg_r.steps_needed};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

@@ sv/asd_div.sv @@
// ----------------------------------------------------------------------------
// asd_div: iterative filter coefficient divider
// Restoring division of dt * 65536 by tau, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module asd_div
  import asd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic [15:0] quotient
);

  logic        busy_r, busy_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] quo_r, quo_nxt;
  logic [15:0] dvs_r;
  logic [16:0] rem_sh;

  assign busy     = busy_r;
  assign quotient = quo_r;
  assign rem_sh   = {rem_r[15:0], 1'b0};

  // One shift-and-subtract step per cycle while busy.
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'(DivSteps);
      rem_nxt  = {1'b0, dividend};
      quo_nxt  = 16'd0;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = rem_sh - {1'b0, dvs_r};
        quo_nxt = {quo_r[14:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[14:0], 1'b0};
      end
      cnt_nxt  = cnt_r - 5'd1;
      busy_nxt = (cnt_r != 5'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

endmodule

@@ sv/asd_datapath.sv @@
// ----------------------------------------------------------------------------
// asd_datapath: filter and peak datapath
// Holds the detector state, the shared multiplier with its rounding, the
// coefficient divider and the result register, all driven by commands.
// ----------------------------------------------------------------------------
module asd_datapath
  import asd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  cmd_t        cmd,
  output status_t     status,
  input  logic [31:0] in_time_ms,
  input  logic [15:0] in_magnitude,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_steps_added
);

  // Saturate a 27-bit signed value to signed 24 bits.
  function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
    logic signed [23:0] r;
    if (v > 27'sd8388607) begin
      r = 24'sh7F_FFFF;
    end else if (v < -27'sd8388608) begin
      r = 24'sh80_0000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  // Sample and detector state.
  logic [31:0]        t_r, prev_time_r, lpt_r;
  logic [15:0]        mag_r;
  logic               seeded_r, rising_r;
  logic signed [23:0] g_r, m_r, pm_r, pa_r, dyn_r;
  logic [7:0]         run_r;
  logic [3:0]         added_r;
  logic               coef_one_r;
  logic signed [42:0] prod_r;
  logic               out_valid_r;
  logic [3:0]         out_steps_r;

  logic [31:0]        dt_raw, dt;
  logic [15:0]        tau_sel, div_q;
  logic               div_busy;
  logic [16:0]        coef_k;
  logic signed [24:0] mag_s, mul_x;
  logic [16:0]        mul_k;
  logic signed [42:0] prod_rnd;
  logic signed [26:0] rnd, g_sum, m_sum, pa_sum, dyn_sum, thr, floor_s, top_s;
  logic [31:0]        gap;
  logic               gap_ok, gap_long, top_gt, peak_take;
  logic [7:0]         run_base, run_new, steps8;
  logic [3:0]         added_new;

  // Elapsed time; equal timestamps count as one millisecond.
  assign dt_raw  = t_r - prev_time_r;
  assign dt      = (dt_raw == 32'd0) ? 32'd1 : dt_raw;
  assign tau_sel = cmd.div_motion ? cfg.motion_tau : cfg.gravity_tau;

  asd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dt[15:0]),
    .divisor  (tau_sel),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // Coefficient is 1.0 for a zero time constant or when dt reaches tau.
  assign coef_k = coef_one_r ? ONE_Q16 : {1'b0, div_q};
  assign mag_s  = signed'({3'b000, mag_r, 6'b00_0000});

  // Operand selection of the shared multiplier.
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_GRAVITY: begin
        mul_x = mag_s - {g_r[23], g_r};
        mul_k = coef_k;
      end
      MUL_MOTION: begin
        mul_x = {dyn_r[23], dyn_r} - {m_r[23], m_r};
        mul_k = coef_k;
      end
      MUL_THRESH: begin
        mul_x = {pa_r[23], pa_r};
        mul_k = {1'b0, cfg.thr_fraction, 8'd0};
      end
      MUL_PEAK: begin
        mul_x = {pm_r[23], pm_r} - {pa_r[23], pa_r};
        mul_k = PEAK_WEIGHT;
      end
      default: begin
        mul_x = '0;
        mul_k = '0;
      end
    endcase
  end

  // Round half up and drop the sixteen fraction bits of the coefficient.
  assign prod_rnd = prod_r + 43'sd32768;
  assign rnd      = prod_rnd[42:16];

  assign g_sum   = {{3{g_r[23]}}, g_r} + rnd;
  assign m_sum   = {{3{m_r[23]}}, m_r} + rnd;
  assign pa_sum  = {{3{pa_r[23]}}, pa_r} + rnd;
  assign dyn_sum = {{2{mag_s[24]}}, mag_s} - {{3{g_r[23]}}, g_r};

  // Peak test against the larger of the scaled average and the floor.
  assign floor_s  = signed'({5'd0, cfg.thr_floor, 6'd0});
  assign thr      = (rnd < floor_s) ? floor_s : rnd;
  assign top_s    = {{3{pm_r[23]}}, pm_r};
  assign top_gt   = top_s > thr;
  assign gap      = t_r - lpt_r;
  assign gap_ok   = gap >= {16'd0, cfg.min_gap};
  assign gap_long = gap > {16'd0, cfg.max_gap};

  // Run length update and the step count it reports.
  assign run_base = gap_long ? 8'd0 : run_r;
  assign run_new  = (run_base == 8'd255) ? 8'd255 : run_base + 8'd1;
  assign steps8   = {4'd0, cfg.steps_needed};
  always_comb begin
    if (run_new == steps8) begin
      added_new = cfg.steps_needed;
    end else if (run_new > steps8) begin
      added_new = 4'd1;
    end else begin
      added_new = 4'd0;
    end
  end

  assign peak_take = !(m_r > pm_r) && rising_r && (m_r < pm_r) && top_gt && gap_ok;

  assign status.seeded   = seeded_r;
  assign status.div_busy = div_busy;
  assign status.pa_blend = peak_take && (pa_r != 24'sd0);
  assign status.out_busy = out_valid_r && out_stall;

  assign out_valid       = out_valid_r;
  assign out_steps_added = out_steps_r;

  // Detector state and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seeded_r    <= 1'b0;
      prev_time_r <= 32'd0;
      g_r         <= '0;
      m_r         <= '0;
      pm_r        <= '0;
      rising_r    <= 1'b0;
      pa_r        <= '0;
      lpt_r       <= LAST_PEAK_RST;
      run_r       <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.seed) begin
        seeded_r    <= 1'b1;
        prev_time_r <= t_r;
        g_r         <= mag_s[23:0];
      end
      if (cmd.upd_g) begin
        g_r <= sat24(g_sum);
      end
      if (cmd.upd_m) begin
        m_r         <= sat24(m_sum);
        prev_time_r <= t_r;
      end
      if (cmd.decide) begin
        if (m_r > pm_r) begin
          rising_r <= 1'b1;
        end else if (rising_r && (m_r < pm_r)) begin
          rising_r <= 1'b0;
          if (peak_take) begin
            run_r <= run_new;
            lpt_r <= t_r;
            if (pa_r == 24'sd0) begin
              pa_r <= pm_r;
            end
          end
        end
      end
      if (cmd.upd_pa) begin
        pa_r <= sat24(pa_sum);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
        pm_r        <= m_r;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_r     <= in_time_ms;
      mag_r   <= in_magnitude;
      added_r <= 4'd0;
    end else if (cmd.decide && peak_take) begin
      added_r <= added_new;
    end
    if (cmd.div_start) begin
      coef_one_r <= (tau_sel == 16'd0) || (dt >= {16'd0, tau_sel});
    end
    if (cmd.calc_dyn) begin
      dyn_r <= sat24(dyn_sum);
    end
    if (cmd.mul_go) begin
      prod_r <= mul_x * signed'({1'b0, mul_k});
    end
    if (cmd.load_out) begin
      out_steps_r <= added_r;
    end
  end

endmodule

@@ sv/asd_ctrl.sv @@
// ----------------------------------------------------------------------------
// asd_ctrl: sequencing controller
// Steps one sample through seeding or both filter updates, the peak decision
// and, on a blend, the peak average update; the result goes to the output.
// ----------------------------------------------------------------------------
module asd_ctrl
  import asd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = status.seeded ? S_GSTART : S_SEED;
      S_SEED:   state_nxt = S_DONE;
      S_GSTART: state_nxt = S_GDIV;
      S_GDIV:   if (!status.div_busy) state_nxt = S_GMUL;
      S_GMUL:   state_nxt = S_GUPD;
      S_GUPD:   state_nxt = S_MSTART;
      S_MSTART: state_nxt = S_MDIV;
      S_MDIV:   if (!status.div_busy) state_nxt = S_MMUL;
      S_MMUL:   state_nxt = S_MUPD;
      S_MUPD:   state_nxt = S_THMUL;
      S_THMUL:  state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = status.pa_blend ? S_PAMUL : S_DONE;
      S_PAMUL:  state_nxt = S_PAUPD;
      S_PAUPD:  state_nxt = S_DONE;
      S_DONE:   if (!status.out_busy) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd         = '0;
    cmd.mul_sel = MUL_GRAVITY;
    in_stall    = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE:   cmd.load = in_valid;
      S_SEED:   cmd.seed = 1'b1;
      S_GSTART: cmd.div_start = 1'b1;
      S_GDIV:   ;
      S_GMUL: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MUL_GRAVITY;
      end
      S_GUPD:   cmd.upd_g = 1'b1;
      S_MSTART: begin
        cmd.div_start  = 1'b1;
        cmd.div_motion = 1'b1;
        cmd.calc_dyn   = 1'b1;
      end
      S_MDIV:   cmd.div_motion = 1'b1;
      S_MMUL: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MUL_MOTION;
      end
      S_MUPD:   cmd.upd_m = 1'b1;
      S_THMUL: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MUL_THRESH;
      end
      S_DECIDE: cmd.decide = 1'b1;
      S_PAMUL: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MUL_PEAK;
      end
      S_PAUPD:  cmd.upd_pa = 1'b1;
      S_DONE:   cmd.load_out = !status.out_busy;
      default:  ;
    endcase
  end

  // A started division reports busy on the following cycle.
  a_div_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> status.div_busy)
    else $error("divider did not start");

  // The multiplier never uses a coefficient that is still being divided.
  a_coef_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mul_go && (cmd.mul_sel == MUL_GRAVITY || cmd.mul_sel == MUL_MOTION))
      |-> !status.div_busy)
    else $error("coefficient used before division finished");

  // A result is never written over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !status.out_busy)
    else $error("result register overwritten");

  // The peak average update only follows a peak decision.
  a_pa_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PAMUL) |-> ($past(state_r) == S_DECIDE))
    else $error("peak average update out of order");

endmodule

@@ sv/accel_step_detector.sv @@
// ----------------------------------------------------------------------------
// accel_step_detector: pedometer step detector
// Counts steps from timestamped acceleration magnitude samples.
// ----------------------------------------------------------------------------
// Each request carries a millisecond timestamp and a Q3.13 magnitude and
// yields one result, the number of steps to add. The first sample after
// reset only seeds the gravity estimate. Every later sample runs two
// 16-step coefficient divisions on the shared divider and three passes
// through the shared multiplier; an accepted peak that blends into the
// peak average adds a fourth pass. A new request is taken as soon as the
// previous result is in the output register, even while that result still
// waits under out_stall.
module accel_step_detector
  import asd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [31:0]      in_time_ms,
  input  logic [15:0]      in_magnitude,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [3:0]       out_steps_added,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  // Configuration registers.
  asd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencing controller.
  asd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Filter and peak datapath.
  asd_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .cmd             (cmd),
    .status          (status),
    .in_time_ms      (in_time_ms),
    .in_magnitude    (in_magnitude),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_steps_added (out_steps_added)
  );

endmodule
